>>> design/rslb_pkg.sv
// Shared types, constants and blend arithmetic for the range/speed LED blender.
package rslb_pkg;

	// Range at which the centre colour reaches full blue (mm).
	localparam int unsigned RANGE_FULL = 500;
	// Speed magnitude that maps to full level.
	localparam int unsigned SPEED_FULL = 120000;

	// x / 500 for x < 2^17: (x * C_RECIP) >> C_SHIFT
	localparam logic [17:0] C_RECIP = 18'd134218;
	localparam int unsigned C_SHIFT = 26;
	// y / 125 for y < 2^15: (y * S_RECIP) >> S_SHIFT
	localparam logic [15:0] S_RECIP = 16'd33555;
	localparam int unsigned S_SHIFT = 22;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} colour_t;

	// One queued word: the three colours for one strip update.
	typedef struct packed {
		colour_t centre;
		colour_t left;
		colour_t right;
	} frame_t;

	// Centre weight out of 256 for blend position 0..3.
	function automatic logic [8:0] centre_weight(logic [1:0] pos);
		logic [8:0] w;
		case (pos)
			2'd0: w = 9'd0;
			2'd1: w = 9'd85;
			2'd2: w = 9'd170;
			2'd3: w = 9'd256;
			default: w = 9'd0;
		endcase
		return w;
	endfunction

	// (e*pe + c*pc)/256, clamp to 255, then /4 down to six bits.
	function automatic logic [5:0] blend(logic [7:0] e_lvl, logic [7:0] c_lvl,
		logic [8:0] pc);
		logic [8:0]  pe;
		logic [17:0] sum;
		logic [9:0]  v;
		pe  = 9'd256 - pc;
		sum = 18'(e_lvl) * 18'(pe) + 18'(c_lvl) * 18'(pc);
		v   = sum[17:8];
		if (v > 10'd255) begin
			v = 10'd255;
		end
		return v[7:2];
	endfunction

endpackage

>>> design/rslb_front.sv
// Front end: accepts readings, tracks the held range and computes the three colours.
module rslb_front #(
	parameter int DEPTH = 4,
	parameter int CW    = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  range_reading,
	input  logic signed [23:0]  left_speed,
	input  logic signed [23:0]  right_speed,
	input  logic [CW-1:0]       q_count,
	output logic                q_push,
	output rslb_pkg::frame_t    q_din
);

	function automatic logic [16:0] abs_clip(logic [23:0] s);
		logic [23:0] mag;
		mag = s[23] ? (~s + 24'd1) : s;
		if (mag > 24'(rslb_pkg::SPEED_FULL)) begin
			return 17'(rslb_pkg::SPEED_FULL);
		end
		return mag[16:0];
	endfunction

	function automatic rslb_pkg::colour_t speed_colour(logic fwd, logic [7:0] lvl);
		rslb_pkg::colour_t c;
		c.r = fwd ? 8'd0 : lvl;
		c.g = fwd ? lvl : 8'd0;
		c.b = 8'd255 - lvl;
		return c;
	endfunction

	logic        accept;
	logic [CW:0] busy;
	logic        held_valid_q;
	logic [14:0] held_q;
	logic [14:0] held_next;
	logic [8:0]  range_clip;

	// stage 1: clipped magnitudes
	logic        v_s1;
	logic        cen_on_s1;
	logic [8:0]  range_clip_s1;
	logic [16:0] lmag_s1;
	logic [16:0] rmag_s1;
	logic        lfwd_s1;
	logic        rfwd_s1;

	// stage 2: reciprocal products
	logic        v_s2;
	logic        cen_on_s2;
	logic [34:0] cprod_s2;
	logic [30:0] lprod_s2;
	logic [30:0] rprod_s2;
	logic        lfwd_s2;
	logic        rfwd_s2;

	logic [16:0] cnum;
	logic [20:0] lnum;
	logic [20:0] rnum;
	logic [7:0]  cb;
	logic [7:0]  llvl;
	logic [7:0]  rlvl;

	// credit check: queue words plus words still in the pipe
	assign busy     = (CW+1)'(q_count) + (CW+1)'(v_s1) + (CW+1)'(v_s2);
	assign in_stall = busy >= (CW+1)'(DEPTH);
	assign accept   = in_valid && !in_stall;

	assign held_next  = !range_reading[15] ? range_reading[14:0] : held_q;
	assign range_clip = (held_next > 15'(rslb_pkg::RANGE_FULL)) ?
		9'(rslb_pkg::RANGE_FULL) : held_next[8:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_q       <= 15'd0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (accept && !range_reading[15]) begin
				held_valid_q <= 1'b1;
				held_q       <= range_reading[14:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cen_on_s1     <= held_valid_q || !range_reading[15];
			range_clip_s1 <= range_clip;
			lmag_s1       <= abs_clip(left_speed);
			rmag_s1       <= abs_clip(right_speed);
			// left is negated before use: forward when the raw value is <= 0
			lfwd_s1       <= left_speed[23] || (left_speed == 24'sd0);
			rfwd_s1       <= !right_speed[23];
		end
	end

	// 255*d and 17*a by shift and add; 17*a/64 keeps the /8000 exact
	assign cnum = {range_clip_s1, 8'd0} - 17'(range_clip_s1);
	assign lnum = {lmag_s1, 4'd0} + 21'(lmag_s1);
	assign rnum = {rmag_s1, 4'd0} + 21'(rmag_s1);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			cen_on_s2 <= cen_on_s1;
			cprod_s2  <= 35'(cnum) * 35'(rslb_pkg::C_RECIP);
			lprod_s2  <= 31'(lnum[20:6]) * 31'(rslb_pkg::S_RECIP);
			rprod_s2  <= 31'(rnum[20:6]) * 31'(rslb_pkg::S_RECIP);
			lfwd_s2   <= lfwd_s1;
			rfwd_s2   <= rfwd_s1;
		end
	end

	assign cb   = cprod_s2[rslb_pkg::C_SHIFT +: 8];
	assign llvl = lprod_s2[rslb_pkg::S_SHIFT +: 8];
	assign rlvl = rprod_s2[rslb_pkg::S_SHIFT +: 8];

	always_comb begin
		q_din.centre.r = cen_on_s2 ? (8'd255 - cb) : 8'd0;
		q_din.centre.g = cen_on_s2 ? 8'd0 : 8'd255;
		q_din.centre.b = cen_on_s2 ? cb : 8'd0;
		q_din.left     = speed_colour(lfwd_s2, llvl);
		q_din.right    = speed_colour(rfwd_s2, rlvl);
	end

	assign q_push = v_s2;

endmodule

>>> design/rslb_fifo.sv
// Short word queue between the front end and the LED sequencer.
module rslb_fifo #(
	parameter int DEPTH = 4,
	parameter int CW    = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rslb_pkg::frame_t din,
	input  logic             pop,
	output logic             not_empty,
	output rslb_pkg::frame_t dout,
	output logic [CW-1:0]    count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	rslb_pkg::frame_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	assign dout      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < CW'(DEPTH))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue underflow");

endmodule

>>> design/rslb_back.sv
// LED sequencer: blends one queued word into eight LED colours, one per cycle while not stalled.
module rslb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  rslb_pkg::frame_t head,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       led_index,
	output logic [5:0]       red_level,
	output logic [5:0]       green_level,
	output logic [5:0]       blue_level,
	output logic             frame_last
);

	logic              out_valid_q;
	logic [2:0]        k_q;
	logic              ld;
	logic              fire;
	logic [1:0]        pos;
	logic [8:0]        pc;
	rslb_pkg::colour_t e_col;
	logic [2:0]        led_q;
	logic [5:0]        red_q;
	logic [5:0]        green_q;
	logic [5:0]        blue_q;
	logic              last_q;

	assign ld    = !out_valid_q || !out_stall;
	assign fire  = ld && head_valid;
	assign q_pop = fire && (k_q == 3'd7);

	// even step: left LED 7-pos, odd step: right LED pos
	assign pos   = k_q[2:1];
	assign pc    = rslb_pkg::centre_weight(pos);
	assign e_col = k_q[0] ? head.right : head.left;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= 3'd0;
		end else if (ld) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				k_q <= k_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			led_q   <= k_q[0] ? {1'b0, pos} : (3'd7 - {1'b0, pos});
			red_q   <= rslb_pkg::blend(e_col.r, head.centre.r, pc);
			green_q <= rslb_pkg::blend(e_col.g, head.centre.g, pc);
			blue_q  <= rslb_pkg::blend(e_col.b, head.centre.b, pc);
			last_q  <= (k_q == 3'd7);
		end
	end

	assign out_valid   = out_valid_q;
	assign led_index   = led_q;
	assign red_level   = red_q;
	assign green_level = green_q;
	assign blue_level  = blue_q;
	assign frame_last  = last_q;

	a_last_is_led3: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> led_q == 3'd3)
		else $error("frame end not on LED 3");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid_q && last_q)
		else $error("word released before its last LED");

endmodule

>>> design/range_speed_led_blender.sv
// Top level of the range/speed LED blender.
// Each accepted word (range reading, left and right wheel speed) yields eight colour
// words for an eight-LED strip, in the order LED 7,0,6,1,5,2,4,3, with frame_last
// marking the eighth. The centre colour follows the last non-negative range (green
// before any, then red near to blue at 500 mm and beyond); the edges follow wheel
// speed (green forward, red reverse, blue the complement), blended toward the centre
// over four positions. The output register emits one colour word per cycle while
// out_stall is low; each input word yields eight of them. A word's colours pass the
// stage-1 and stage-2 registers before the queue push, and its first LED is loaded
// into the output register once the word heads the queue and the register is free.
// The queue of FIFO_DEPTH words lets the input side run ahead while the output is
// stalled; input stall rises when queued plus in-flight words fill it.
module range_speed_led_blender #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] range_reading,
	input  logic signed [23:0] left_speed,
	input  logic signed [23:0] right_speed,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         led_index,
	output logic [5:0]         red_level,
	output logic [5:0]         green_level,
	output logic [5:0]         blue_level,
	output logic               frame_last
);

	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic             q_push;
	logic             q_pop;
	logic             q_not_empty;
	logic [CW-1:0]    q_count;
	rslb_pkg::frame_t q_din;
	rslb_pkg::frame_t q_dout;

	// classify and compute colours
	rslb_front #(
		.DEPTH (FIFO_DEPTH),
		.CW    (CW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.range_reading (range_reading),
		.left_speed    (left_speed),
		.right_speed   (right_speed),
		.q_count       (q_count),
		.q_push        (q_push),
		.q_din         (q_din)
	);

	// decoupling queue
	rslb_fifo #(
		.DEPTH (FIFO_DEPTH),
		.CW    (CW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.din       (q_din),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.dout      (q_dout),
		.count     (q_count)
	);

	// per-LED blend and output register
	rslb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_not_empty),
		.head        (q_dout),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.led_index   (led_index),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level),
		.frame_last  (frame_last)
	);

endmodule

>>> dv/rslb_checker.sv
// Checker for the LED blender: predicts the eight colour words of each input word and compares.
`timescale 1ns / 1ps

module rslb_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] range_reading,
	input  logic signed [23:0] left_speed,
	input  logic signed [23:0] right_speed,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [2:0]         led_index,
	input  logic [5:0]         red_level,
	input  logic [5:0]         green_level,
	input  logic [5:0]         blue_level,
	input  logic               frame_last,
	output int                 words_due,
	output int                 mismatches
);

	typedef struct packed {
		logic [2:0] led;
		logic [5:0] red;
		logic [5:0] green;
		logic [5:0] blue;
		logic       is_last;
	} led_word_t;

	led_word_t   led_words_due[$];
	bit          range_known;
	logic [14:0] range_kept;

	// Wheel speed to edge colour; v is already in forward-positive sense.
	function automatic rslb_pkg::colour_t wheel_colour(input logic signed [24:0] v);
		rslb_pkg::colour_t c;
		logic [24:0]       a;
		int unsigned       mag;
		int unsigned       lvl;
		a   = v[24] ? 25'(-v) : 25'(v);
		mag = (a > rslb_pkg::SPEED_FULL) ? rslb_pkg::SPEED_FULL : int'(a);
		lvl = mag * 255 / rslb_pkg::SPEED_FULL;
		c.r = v[24] ? 8'(lvl) : 8'd0;
		c.g = v[24] ? 8'd0 : 8'(lvl);
		c.b = 8'(255 - lvl);
		return c;
	endfunction

	// One channel at blend position pos (0..3).
	function automatic logic [5:0] mix(input int unsigned e, input int unsigned c,
		input int unsigned pos);
		int unsigned wc;
		int unsigned v;
		wc = pos * 256 / 3;
		v  = (e * (256 - wc) + c * wc) / 256;
		if (v > 255)
			v = 255;
		return 6'(v / 4);
	endfunction

	task automatic predict_strip(input logic signed [15:0] rr,
		input logic signed [23:0] ls, input logic signed [23:0] rs);
		rslb_pkg::colour_t  mid;
		rslb_pkg::colour_t  lc;
		rslb_pkg::colour_t  rc;
		logic signed [24:0] lv;
		int unsigned        d;
		led_word_t          w;
		if (!rr[15]) begin
			range_kept  = rr[14:0];
			range_known = 1'b1;
		end
		if (!range_known) begin
			mid = '{r: 8'd0, g: 8'd255, b: 8'd0};
		end else begin
			d     = (range_kept > rslb_pkg::RANGE_FULL) ?
				rslb_pkg::RANGE_FULL : int'(range_kept);
			mid.b = 8'(255 * d / rslb_pkg::RANGE_FULL);
			mid.r = 8'd255 - mid.b;
			mid.g = 8'd0;
		end
		// left encoder counts the other way round
		lv = 25'sd0 - $signed({ls[23], ls});
		lc = wheel_colour(lv);
		rc = wheel_colour($signed({rs[23], rs}));
		for (int i = 0; i < 4; i++) begin
			w.led     = 3'(7 - i);
			w.red     = mix(lc.r, mid.r, i);
			w.green   = mix(lc.g, mid.g, i);
			w.blue    = mix(lc.b, mid.b, i);
			w.is_last = 1'b0;
			led_words_due.push_back(w);
			w.led     = 3'(i);
			w.red     = mix(rc.r, mid.r, i);
			w.green   = mix(rc.g, mid.g, i);
			w.blue    = mix(rc.b, mid.b, i);
			w.is_last = (i == 3);
			led_words_due.push_back(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		led_word_t want;
		if (!arst_n) begin
			range_known = 1'b0;
			range_kept  = '0;
			led_words_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (led_words_due.size() == 0) begin
					$error("unexpected LED word: led %0d rgb %0d/%0d/%0d last %0b",
						led_index, red_level, green_level, blue_level, frame_last);
					mismatches++;
				end else begin
					want = led_words_due.pop_front();
					if (led_index !== want.led) begin
						$error("led_index: expected %0d, got %0d", want.led, led_index);
						mismatches++;
					end
					if (red_level !== want.red) begin
						$error("red_level: expected %0d, got %0d", want.red, red_level);
						mismatches++;
					end
					if (green_level !== want.green) begin
						$error("green_level: expected %0d, got %0d", want.green, green_level);
						mismatches++;
					end
					if (blue_level !== want.blue) begin
						$error("blue_level: expected %0d, got %0d", want.blue, blue_level);
						mismatches++;
					end
					if (frame_last !== want.is_last) begin
						$error("frame_last: expected %0b, got %0b", want.is_last, frame_last);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_strip(range_reading, left_speed, right_speed);
		end
		// nonblocking so the stimulus side reads a settled count
		words_due <= led_words_due.size();
	end

endmodule

>>> dv/tb_range_speed_led_blender.sv
// Testbench top for the LED blender: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_range_speed_led_blender;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] range_reading;
	logic signed [23:0] left_speed;
	logic signed [23:0] right_speed;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         led_index;
	logic [5:0]         red_level;
	logic [5:0]         green_level;
	logic [5:0]         blue_level;
	logic               frame_last;

	int words_due;
	int mismatches;

	// calm: no idling on either side. hold_cycles: request for one long
	// output hold, taken and counted down by the receiver process.
	bit calm;
	int hold_cycles;

	range_speed_led_blender dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.range_reading(range_reading),
		.left_speed   (left_speed),
		.right_speed  (right_speed),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.led_index    (led_index),
		.red_level    (red_level),
		.green_level  (green_level),
		.blue_level   (blue_level),
		.frame_last   (frame_last)
	);

	rslb_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.range_reading(range_reading),
		.left_speed   (left_speed),
		.right_speed  (right_speed),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.led_index    (led_index),
		.red_level    (red_level),
		.green_level  (green_level),
		.blue_level   (blue_level),
		.frame_last   (frame_last),
		.words_due    (words_due),
		.mismatches   (mismatches)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop at 2 ms. Slowest legal run: ~320 words x 8 LED words, with output
	// stall bursts, sender gaps and the long hold; the stop time leaves plenty of
	// margin.
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// Offer one input word and hold it until the block takes it. Returns at
	// the accepting edge, or after a random idle burst that may follow it.
	task automatic offer(input logic signed [15:0] rr, input logic signed [23:0] ls,
		input logic signed [23:0] rs);
		in_valid      <= 1'b1;
		range_reading <= rr;
		left_speed    <= ls;
		right_speed   <= rs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Sender pause: nothing offered until every LED word has come out.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
	endtask

	// Random word: range mostly near the 0..500 ramp or negative (no new
	// reading), speeds mostly around the 120000 clip point, the rest raw bits.
	task automatic offer_random();
		logic signed [15:0] rr;
		logic signed [23:0] ls;
		logic signed [23:0] rs;
		int                 pick;
		int                 s;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			rr = 16'($urandom_range(0, 600));
		else if (pick < 7)
			rr = -16'($urandom_range(1, 32768));
		else
			rr = 16'($urandom());
		if ($urandom_range(0, 9) < 6) begin
			s  = int'($urandom_range(0, 260000)) - 130000;
			ls = s[23:0];
		end else begin
			ls = 24'($urandom());
		end
		if ($urandom_range(0, 9) < 6) begin
			s  = int'($urandom_range(0, 260000)) - 130000;
			rs = s[23:0];
		end else begin
			rs = 24'($urandom());
		end
		offer(rr, ls, rs);
	endtask

	// Receiver: random stall bursts, or one long hold on request.
	initial begin : sink
		int burst;
		burst       = 0;
		out_stall   = 1'b0;
		hold_cycles = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (burst > 0) begin
				out_stall <= 1'b1;
				burst--;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				burst = $urandom_range(1, 3) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		range_reading = '0;
		left_speed    = '0;
		right_speed   = '0;
		calm          = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed. Left speed is negated inside the block, so a positive
		// left value reads as reverse.
		// no range held yet: centre stays green
		offer(-16'sd1, 24'sd0, 24'sd0);
		offer(-16'sd32768, 24'sd120000, -24'sd120000);
		offer(-16'sd5, -24'sd120000, 24'sd120000);
		// zero range is a real reading: full red centre; most negative speeds
		offer(16'sd0, -24'sd8388608, -24'sd8388608);
		offer(-16'sd1, 24'sd8388607, 24'sd8388607);
		// around the 500 mm knee
		offer(16'sd500, 24'sd119999, 24'sd120001);
		offer(16'sd499, -24'sd120001, -24'sd119999);
		offer(16'sd501, 24'sd1, -24'sd1);
		offer(16'sd32767, -24'sd1, 24'sd1);
		offer(16'sd250, 24'sd60000, -24'sd60000);
		offer(-16'sd32768, 24'sd0, 24'sd8388607);
		offer(16'sd1, -24'sd8388607, 24'sd0);
		offer(16'sd16384, 24'sd470, -24'sd471);
		offer(16'sd100, 24'sd0, 24'sd0);
		offer(16'sd2, 24'sd8388607, -24'sd8388607);
		drain();

		repeat (100) offer_random();

		// Long output hold while words keep coming: the queue fills and
		// in_stall has to rise.
		hold_cycles = 160;
		repeat (30) offer_random();
		drain();

		repeat (40) offer_random();
		// a stretch at full rate in mid-run
		calm = 1'b1;
		repeat (30) offer_random();
		calm = 1'b0;
		repeat (60) offer_random();
		drain();

		// tail: no idling on either side
		calm = 1'b1;
		repeat (45) offer_random();
		in_valid <= 1'b0;

		// Wait out every expected LED word, then a few cycles more in case
		// a stray word follows.
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (mismatches == 0 && words_due == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> files.f
design/rslb_pkg.sv
design/rslb_front.sv
design/rslb_fifo.sv
design/rslb_back.sv
design/range_speed_led_blender.sv
dv/rslb_checker.sv
dv/tb_range_speed_led_blender.sv
